>>> hw/rtl/lnts_pkg.sv
`default_nettype none

package lnts_pkg;

    localparam int TERMS     = 16;
    localparam int FRAC_BITS = 30;
    localparam int X_W       = 32;
    localparam int MAG_W     = FRAC_BITS + 1;        // magnitudes up to 1.0 inclusive
    localparam int ACC_W     = 36;
    localparam int IDX_W     = $clog2(TERMS + 1);
    localparam int RECIP_W   = 32;

    localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic                    oor;
        logic                    d_neg;
        logic [MAG_W-1:0]        d_mag;
        logic                    p_neg;
        logic [MAG_W-1:0]        p_mag;
        logic signed [ACC_W-1:0] acc;
    } lnts_data_t;

endpackage

`default_nettype wire

>>> hw/rtl/ln_taylor_series_unit.sv
`default_nettype none

// ln(x) by the Mercator series, x unsigned Q2.30, result signed Q5.30.
// Input channel: arg_valid / arg_stall with x_value. Output channel:
// res_valid / res_stall with ln_value and out_of_range.
// An item with x >= 2.0 returns ln_value = 0 and out_of_range = 1.
// One item is accepted every cycle while arg_stall is low. An item passes
// through an input register, a chain of TERMS cells of four
// stages each (power multiply, reciprocal multiply, quotient fix-up,
// accumulate) and the output register.
// When res_stall holds a waiting result, the whole chain freezes and
// arg_stall rises in the same cycle; items in flight are kept, not dropped.
// Reset clears every valid flag; the chain is empty afterwards and accepts
// an item in the first cycle out of reset.
module ln_taylor_series_unit
    import lnts_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     arg_valid,
    output logic                          arg_stall,
    input  wire logic [X_W-1:0]           x_value,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic signed [ACC_W-1:0]       ln_value,
    output logic                          out_of_range
);

    logic                    adv;
    logic                    chain_valid [0:TERMS];
    lnts_data_t              chain_data  [0:TERMS];

    logic                    in_valid_reg;
    lnts_data_t              in_data_reg, in_data_next;
    logic                    res_valid_reg;
    logic signed [ACC_W-1:0] ln_value_reg, ln_value_next;
    logic                    oor_reg;
    logic [MAG_W-1:0]        x_low;

    assign adv       = !(res_valid_reg && res_stall);
    assign arg_stall = !adv;

    // d = x - 1 as sign and magnitude
    always_comb
    begin
        x_low              = x_value[MAG_W-1:0];
        in_data_next.oor   = x_value[X_W-1];
        in_data_next.d_neg = (x_value[X_W-1:X_W-2] == 2'b00);
        if (in_data_next.d_neg)
            in_data_next.d_mag = ONE_Q30 - x_low;
        else
            in_data_next.d_mag = x_low - ONE_Q30;
        in_data_next.p_neg = in_data_next.d_neg;
        in_data_next.p_mag = in_data_next.d_mag;
        in_data_next.acc   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= arg_valid;
            res_valid_reg <= chain_valid[TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_data_reg  <= in_data_next;
            ln_value_reg <= ln_value_next;
            oor_reg      <= chain_data[TERMS].oor;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    generate
        for (genvar g = 0; g < TERMS; g++)
        begin : g_cell
            localparam logic [IDX_W-1:0]   IDX   = IDX_W'(g + 1);
            // unused by the first cell, which divides by one
            localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / 64'(g + 1));

            lnts_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .term_idx   (IDX),
                .recip      (RECIP),
                .prev_valid (chain_valid[g]),
                .prev_data  (chain_data[g]),
                .next_valid (chain_valid[g+1]),
                .next_data  (chain_data[g+1])
            );
        end
    endgenerate

    // sum magnitude stays below the harmonic bound, so no saturation is needed
    always_comb
    begin
        if (chain_data[TERMS].oor)
            ln_value_next = '0;
        else
            ln_value_next = chain_data[TERMS].acc;
    end

    assign res_valid    = res_valid_reg;
    assign ln_value     = ln_value_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lnts_cell.sv
`default_nettype none

// One series term: power update, reciprocal multiply, quotient fix-up, accumulate.
module lnts_cell
    import lnts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic [IDX_W-1:0]   term_idx,
    input  wire logic [RECIP_W-1:0] recip,
    input  wire logic               prev_valid,
    input  wire lnts_data_t         prev_data,
    output logic                    next_valid,
    output lnts_data_t              next_data
);

    localparam int POW_W = 2 * MAG_W;
    localparam int RP_W  = MAG_W + RECIP_W;
    localparam int BP_W  = MAG_W + IDX_W;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    lnts_data_t       s1_data_reg, s2_data_reg, s3_data_reg, s4_data_reg;
    lnts_data_t       s1_data_next, s4_data_next;
    logic [MAG_W-1:0] s2_q0_reg, s2_q0_next;
    logic [MAG_W-1:0] s3_q_reg, s3_q_next;

    logic [POW_W-1:0]        pow_prod;
    logic [RP_W-1:0]         recip_prod;
    logic [BP_W-1:0]         back_prod;
    logic [BP_W-1:0]         remainder;
    logic                    term_neg;
    logic signed [ACC_W-1:0] q_ext;

    // stage 1: p = trunc(p * d / 2^30); the first term uses d itself
    always_comb
    begin
        pow_prod     = POW_W'(prev_data.p_mag) * POW_W'(prev_data.d_mag);
        s1_data_next = prev_data;
        if (term_idx != IDX_W'(1))
        begin
            s1_data_next.p_mag = pow_prod[FRAC_BITS +: MAG_W];
            s1_data_next.p_neg = prev_data.p_neg ^ prev_data.d_neg;
        end
    end

    // stage 2: quotient estimate, low by at most one
    always_comb
    begin
        recip_prod = RP_W'(s1_data_reg.p_mag) * RP_W'(recip);
        if (term_idx == IDX_W'(1))
            s2_q0_next = s1_data_reg.p_mag;
        else
            s2_q0_next = recip_prod[RECIP_W +: MAG_W];
    end

    // stage 3: correct the estimate from the remainder
    always_comb
    begin
        back_prod = BP_W'(s2_q0_reg) * BP_W'(term_idx);
        remainder = BP_W'(s2_data_reg.p_mag) - back_prod;
        if (remainder >= BP_W'(term_idx))
            s3_q_next = s2_q0_reg + MAG_W'(1);
        else
            s3_q_next = s2_q0_reg;
    end

    // stage 4: even terms are subtracted
    always_comb
    begin
        term_neg     = s3_data_reg.p_neg ^ ~term_idx[0];
        q_ext        = $signed({{(ACC_W - MAG_W){1'b0}}, s3_q_reg});
        s4_data_next = s3_data_reg;
        if (term_neg)
            s4_data_next.acc = s3_data_reg.acc - q_ext;
        else
            s4_data_next.acc = s3_data_reg.acc + q_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= prev_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_data_reg <= s1_data_next;
            s2_data_reg <= s1_data_reg;
            s2_q0_reg   <= s2_q0_next;
            s3_data_reg <= s2_data_reg;
            s3_q_reg    <= s3_q_next;
            s4_data_reg <= s4_data_next;
        end
    end

    assign next_valid = s4_valid_reg;
    assign next_data  = s4_data_reg;

    // powers never grow past 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_data_reg.oor |-> s1_data_reg.p_mag <= ONE_Q30)
        else $error("power magnitude above one");

    // corrected quotient never overshoots
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_data_reg.oor |->
            (BP_W'(s3_q_reg) * BP_W'(term_idx)) <= BP_W'(s3_data_reg.p_mag))
        else $error("quotient too large");

    // an item moves one stage per advance
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_valid_reg |=> s3_valid_reg)
        else $error("item lost between stages");

endmodule

`default_nettype wire
